>>> rtl/acc_pkg.sv
// ============================================================================
// Alarm clock controller package
// Shared constants, codes and types for the 24-hour alarm clock controller.
// ============================================================================
`default_nettype none

package acc_pkg;

    // Field widths
    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned MIN_W      = 6;
    localparam int unsigned SEC_W      = 6;
    localparam int unsigned SUBSEC_W   = 10;
    localparam int unsigned BTN_W      = 4;
    localparam int unsigned LOCKOUT_W  = 8;
    localparam int unsigned IDLE_W     = 13;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 32;

    // Time limits
    localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;
    localparam logic [HOUR_W-1:0] LAST_HOUR     = 5'd23;
    localparam logic [MIN_W-1:0]  LAST_MINUTE   = 6'd59;
    localparam logic [SEC_W-1:0]  LAST_SECOND   = 6'd59;
    localparam logic [IDLE_W-1:0] IDLE_MAX      = 13'd8191;

    // Reset values
    localparam logic [HOUR_W-1:0]    RESET_HOUR     = 5'd12;
    localparam logic [LOCKOUT_W-1:0] RESET_DEBOUNCE = 8'd150;
    localparam logic [IDLE_W-1:0]    RESET_TIMEOUT  = 13'd5000;
    localparam logic [SUBSEC_W-1:0]  RESET_MSPS     = 10'd1000;

    // Mode codes seen on the result channel
    localparam logic [MODE_W-1:0] MODE_RUN       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_TIME  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET_ALARM = 2'd2;

    // Button bit positions (active low levels)
    localparam int unsigned BTN_HOUR_UP = 0;
    localparam int unsigned BTN_HOUR_DN = 1;
    localparam int unsigned BTN_MIN_UP  = 2;
    localparam int unsigned BTN_MIN_DN  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_MSPS     = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

>>> rtl/alarm_clock_controller_core.sv
// ============================================================================
// Alarm clock controller core
// 24-hour clock with one alarm, button handling, debounce and setting timeout.
// ============================================================================
//
// Usage:
//   The slave channel carries one transfer per clock item: a millisecond tick
//   flag and the four raw active-low button levels. Every accepted transfer
//   produces exactly one transfer on the master channel holding the clock
//   time, the alarm time, the mode code, the buzzer state and the time-valid
//   flag as they stand after that item.
//   The result is registered and shows on the master channel in the cycle
//   after the input transfer. Throughput is one item per cycle while the
//   receiver does not stall; all state updates for an item are made together.
//   When the receiver stalls, the result is held in the output register and
//   s_axis_tready stays high only while that register is free or is being
//   drained in the same cycle.
//   The configuration port writes the debounce time, the setting timeout and
//   the tick count per second; write it only while no item is in flight.
//   Synchronous reset puts the clock and alarm at 12:00:00, normal mode, time
//   not set, buzzer off, all buttons released, and the registers at their
//   default values.
// ============================================================================
`default_nettype none

module alarm_clock_controller_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [acc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [acc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input channel
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] ms_tick, [4:1] button_levels, [7:5] zero
    input  wire logic [acc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Result channel
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [4:0] clock_hours, [10:5] clock_minutes, [16:11] clock_seconds,
    // [21:17] wake_hour, [27:22] wake_minute, [29:28] mode_code,
    // [30] buzzer_on, [31] time_valid
    output logic [acc_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

    // Configuration registers
    logic [acc_pkg::LOCKOUT_W-1:0] debounce_reg;
    logic [acc_pkg::IDLE_W-1:0]    timeout_reg;
    logic [acc_pkg::SUBSEC_W-1:0]  msps_reg;

    // Clock state
    logic [acc_pkg::HOUR_W-1:0]    hour_reg,      hour_next;
    logic [acc_pkg::MIN_W-1:0]     minute_reg,    minute_next;
    logic [acc_pkg::SEC_W-1:0]     second_reg,    second_next;
    logic [acc_pkg::SUBSEC_W-1:0]  subsec_reg,    subsec_next;
    logic [acc_pkg::HOUR_W-1:0]    al_hour_reg,   al_hour_next;
    logic [acc_pkg::MIN_W-1:0]     al_minute_reg, al_minute_next;
    logic                          in_setting_reg, in_setting_next;
    logic                          edit_alarm_reg, edit_alarm_next;
    logic                          time_set_reg,   time_set_next;
    logic                          ringing_reg,    ringing_next;
    logic                          fired_reg,      fired_next;
    logic [acc_pkg::BTN_W-1:0]     prev_btn_reg;
    logic [acc_pkg::LOCKOUT_W-1:0] lockout_reg,   lockout_next;
    logic [acc_pkg::IDLE_W-1:0]    idle_reg,      idle_next;

    // Output register
    logic                          m_valid_reg;
    logic [acc_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Item decode
    logic                          in_xfer;
    logic                          tick;
    logic [acc_pkg::BTN_W-1:0]     levels;
    logic [acc_pkg::BTN_W-1:0]     pressed;
    logic [acc_pkg::SUBSEC_W:0]    subsec_inc;
    logic                          action;
    logic [acc_pkg::HOUR_W-1:0]    tgt_hour;
    logic [acc_pkg::MIN_W-1:0]     tgt_minute;
    logic [acc_pkg::MODE_W-1:0]    mode_next;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign tick    = s_axis_tdata[0];
    assign levels  = s_axis_tdata[acc_pkg::BTN_W:1];
    assign pressed = prev_btn_reg & ~levels;
    assign subsec_inc = {1'b0, subsec_reg} + {{acc_pkg::SUBSEC_W{1'b0}}, 1'b1};

    // Next state for one item: tick, buttons, timeout, then alarm check.
    always_comb begin
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        subsec_next     = subsec_reg;
        al_hour_next    = al_hour_reg;
        al_minute_next  = al_minute_reg;
        in_setting_next = in_setting_reg;
        edit_alarm_next = edit_alarm_reg;
        time_set_next   = time_set_reg;
        ringing_next    = ringing_reg;
        fired_next      = fired_reg;
        lockout_next    = lockout_reg;
        idle_next       = idle_reg;
        action          = 1'b0;
        tgt_hour        = '0;
        tgt_minute      = '0;

        // Millisecond tick: lockout, idle count and the running clock.
        if (tick) begin
            if (lockout_reg != '0) begin
                lockout_next = lockout_reg - 1'b1;
            end
            if (in_setting_reg) begin
                if (idle_reg != acc_pkg::IDLE_MAX) begin
                    idle_next = idle_reg + 1'b1;
                end
            end else if (subsec_inc >= {1'b0, msps_reg}) begin
                subsec_next = '0;
                if (second_reg == acc_pkg::LAST_SECOND) begin
                    second_next = '0;
                    fired_next  = 1'b0;
                    if (minute_reg == acc_pkg::LAST_MINUTE) begin
                        minute_next = '0;
                        if (hour_reg == acc_pkg::LAST_HOUR) begin
                            hour_next = '0;
                        end else begin
                            hour_next = hour_reg + 1'b1;
                        end
                    end else begin
                        minute_next = minute_reg + 1'b1;
                    end
                end else begin
                    second_next = second_reg + 1'b1;
                end
            end else begin
                subsec_next = subsec_inc[acc_pkg::SUBSEC_W-1:0];
            end
        end

        // Button presses, taken only when no lockout is running.
        if (lockout_next == '0) begin
            if (!in_setting_reg) begin
                if (pressed[acc_pkg::BTN_MIN_DN] && ringing_reg) begin
                    ringing_next = 1'b0;
                    action       = 1'b1;
                end else if (pressed[acc_pkg::BTN_HOUR_DN] && !ringing_reg) begin
                    in_setting_next = 1'b1;
                    edit_alarm_next = 1'b1;
                    idle_next       = '0;
                    action          = 1'b1;
                end else if (pressed[acc_pkg::BTN_HOUR_UP] && !ringing_reg) begin
                    in_setting_next = 1'b1;
                    edit_alarm_next = 1'b0;
                    idle_next       = '0;
                    action          = 1'b1;
                end
            end else begin
                tgt_hour   = edit_alarm_reg ? al_hour_reg : hour_next;
                tgt_minute = edit_alarm_reg ? al_minute_reg : minute_next;
                action     = 1'b1;
                if (pressed[acc_pkg::BTN_HOUR_UP]) begin
                    tgt_hour = (tgt_hour == acc_pkg::LAST_HOUR) ? '0 : tgt_hour + 1'b1;
                end else if (pressed[acc_pkg::BTN_HOUR_DN]) begin
                    tgt_hour = (tgt_hour == '0) ? acc_pkg::LAST_HOUR : tgt_hour - 1'b1;
                end else if (pressed[acc_pkg::BTN_MIN_UP]) begin
                    tgt_minute = (tgt_minute == acc_pkg::LAST_MINUTE) ? '0
                                                                      : tgt_minute + 1'b1;
                    if (!edit_alarm_reg) begin
                        second_next = '0;
                    end
                end else if (pressed[acc_pkg::BTN_MIN_DN]) begin
                    tgt_minute = (tgt_minute == '0) ? acc_pkg::LAST_MINUTE
                                                    : tgt_minute - 1'b1;
                    if (!edit_alarm_reg) begin
                        second_next = '0;
                    end
                end else begin
                    action = 1'b0;
                end
                if (action) begin
                    idle_next = '0;
                    if (edit_alarm_reg) begin
                        al_hour_next   = tgt_hour;
                        al_minute_next = tgt_minute;
                    end else begin
                        hour_next   = tgt_hour;
                        minute_next = tgt_minute;
                    end
                end
            end
            if (action) begin
                lockout_next = debounce_reg;
            end
        end

        // Setting timeout returns to normal mode.
        if (in_setting_next && (idle_next >= timeout_reg)) begin
            if (!edit_alarm_next) begin
                time_set_next = 1'b1;
                fired_next    = 1'b0;
            end
            in_setting_next = 1'b0;
        end

        // Alarm fires once per matching minute.
        if (time_set_next && !in_setting_next && !ringing_next && !fired_next &&
            (hour_next == al_hour_next) && (minute_next == al_minute_next)) begin
            ringing_next = 1'b1;
            fired_next   = 1'b1;
        end
    end

    // Result packing
    always_comb begin
        if (!in_setting_next) begin
            mode_next = acc_pkg::MODE_RUN;
        end else if (edit_alarm_next) begin
            mode_next = acc_pkg::MODE_SET_ALARM;
        end else begin
            mode_next = acc_pkg::MODE_SET_TIME;
        end
        m_data_next = {time_set_next, ringing_next, mode_next, al_minute_next,
                       al_hour_next, second_next, minute_next, hour_next};
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= acc_pkg::RESET_DEBOUNCE;
            timeout_reg  <= acc_pkg::RESET_TIMEOUT;
            msps_reg     <= acc_pkg::RESET_MSPS;
        end else if (cfg_we) begin
            case (cfg_addr)
                acc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_wdata[acc_pkg::LOCKOUT_W-1:0];
                acc_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_wdata[acc_pkg::IDLE_W-1:0];
                acc_pkg::CFG_MSPS:     msps_reg     <= cfg_wdata[acc_pkg::SUBSEC_W-1:0];
                default: ;
            endcase
        end
    end

    // State update on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg       <= acc_pkg::RESET_HOUR;
            minute_reg     <= '0;
            second_reg     <= '0;
            subsec_reg     <= '0;
            al_hour_reg    <= acc_pkg::RESET_HOUR;
            al_minute_reg  <= '0;
            in_setting_reg <= 1'b0;
            edit_alarm_reg <= 1'b0;
            time_set_reg   <= 1'b0;
            ringing_reg    <= 1'b0;
            fired_reg      <= 1'b0;
            prev_btn_reg   <= '1;
            lockout_reg    <= '0;
            idle_reg       <= '0;
        end else if (in_xfer) begin
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            subsec_reg     <= subsec_next;
            al_hour_reg    <= al_hour_next;
            al_minute_reg  <= al_minute_next;
            in_setting_reg <= in_setting_next;
            edit_alarm_reg <= edit_alarm_next;
            time_set_reg   <= time_set_next;
            ringing_reg    <= ringing_next;
            fired_reg      <= fired_next;
            prev_btn_reg   <= levels;
            lockout_reg    <= lockout_next;
            idle_reg       <= idle_next;
        end
    end

    // Output register: loads on every input transfer, empties when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    // Every accepted item leaves a result waiting in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_valid_reg)
        else $error("accepted item produced no result");

    // The alarm can only ring once the time has been set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ringing_reg |-> time_set_reg)
        else $error("alarm ringing before time was set");

    // A ringing alarm and a setting mode never coexist.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ringing_reg |-> !in_setting_reg)
        else $error("alarm ringing while in a setting mode");

    // Clock fields stay in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hour_reg < acc_pkg::HOURS_PER_DAY) && (minute_reg <= acc_pkg::LAST_MINUTE) &&
        (al_hour_reg < acc_pkg::HOURS_PER_DAY) && (al_minute_reg <= acc_pkg::LAST_MINUTE))
        else $error("clock or alarm field out of range");
`endif

endmodule

`default_nettype wire
